FILE: rtl/core/rms_pkg.sv
// shared types and constants for the regret matching strategy block
// no dependencies
package rms_pkg;

  localparam int MAX_ACTIONS = 16;
  localparam int MAX_BUCKETS = 256;
  localparam int STORE_DEPTH = MAX_ACTIONS * MAX_BUCKETS;
  localparam int ADDR_W      = $clog2(STORE_DEPTH);
  localparam int PROB_W      = 17;
  localparam int SUM_W       = 36;
  localparam int POS_W       = 31;
  localparam int QSTEPS      = 17;

  localparam logic [PROB_W-1:0] ONE_Q16 = 17'd65536;

  // configuration register indexes
  localparam logic [1:0] REG_LAYOUT  = 2'd0;
  localparam logic [1:0] REG_BUCKETS = 2'd1;
  localparam logic [1:0] REG_ACTIONS = 2'd2;

  typedef struct packed {
    logic              is_query;
    logic              uniform;
    logic [ADDR_W-1:0] addr;     // write address or first read address
    logic [8:0]        stride;
    logic [4:0]        na;
    logic [31:0]       data;
  } rms_cmd_t;

  // floor(65536 / actions)
  function automatic logic [PROB_W-1:0] uniform_prob(input logic [4:0] na);
    logic [PROB_W-1:0] p;
    unique case (na)
      5'd1:    p = 17'd65536;
      5'd2:    p = 17'd32768;
      5'd3:    p = 17'd21845;
      5'd4:    p = 17'd16384;
      5'd5:    p = 17'd13107;
      5'd6:    p = 17'd10922;
      5'd7:    p = 17'd9362;
      5'd8:    p = 17'd8192;
      5'd9:    p = 17'd7281;
      5'd10:   p = 17'd6553;
      5'd11:   p = 17'd5957;
      5'd12:   p = 17'd5461;
      5'd13:   p = 17'd5041;
      5'd14:   p = 17'd4681;
      5'd15:   p = 17'd4369;
      5'd16:   p = 17'd4096;
      default: p = '0;
    endcase
    return p;
  endfunction

endpackage

FILE: rtl/core/rms_front.sv
// front end: configuration registers, request acceptance and address calculation
// depends on rms_pkg
module rms_front import rms_pkg::*; (
  input  logic           clk,
  input  logic           rst_n,
  input  logic           cfg_we,
  input  logic [1:0]     cfg_index,
  input  logic [8:0]     cfg_wdata,
  input  logic           in_valid,
  output logic           in_ready,
  input  logic           in_kind,
  input  logic [7:0]     in_bucket,
  input  logic [3:0]     in_action,
  input  logic [31:0]    in_regret_value,
  input  logic           clearing,
  input  logic           q_full,
  output logic           q_push,
  output rms_cmd_t       q_cmd
);

  logic       layout_r;
  logic [8:0] buckets_r;
  logic [4:0] actions_r;
  logic [8:0] nb;
  logic [4:0] na;
  logic       b_ok, a_ok;
  logic [12:0] waddr_bm, waddr_am, qbase_bm;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      layout_r  <= 1'b0;
      buckets_r <= 9'd256;
      actions_r <= 5'd16;
    end else if (cfg_we) begin
      unique case (cfg_index)
        REG_LAYOUT:  layout_r  <= cfg_wdata[0];
        REG_BUCKETS: buckets_r <= cfg_wdata;
        REG_ACTIONS: actions_r <= cfg_wdata[4:0];
        default: ;
      endcase
    end
  end

  always_comb begin
    nb = (buckets_r > 9'(MAX_BUCKETS)) ? 9'(MAX_BUCKETS) : buckets_r;
    na = (actions_r > 5'(MAX_ACTIONS)) ? 5'(MAX_ACTIONS) : actions_r;
    b_ok = {1'b0, in_bucket} < nb;
    a_ok = {1'b0, in_action} < na;
    qbase_bm = {5'd0, in_bucket} * {8'd0, na};
    waddr_bm = qbase_bm + {9'd0, in_action};
    waddr_am = ({9'd0, in_action} * {4'd0, nb}) + {5'd0, in_bucket};
  end

  always_comb begin
    q_cmd.is_query = in_kind;
    q_cmd.uniform  = !b_ok;
    q_cmd.na       = na;
    q_cmd.data     = in_regret_value;
    q_cmd.stride   = layout_r ? nb : 9'd1;
    if (in_kind)
      q_cmd.addr = layout_r ? ADDR_W'(in_bucket) : qbase_bm[ADDR_W-1:0];
    else
      q_cmd.addr = layout_r ? waddr_am[ADDR_W-1:0] : waddr_bm[ADDR_W-1:0];
  end

  assign in_ready = !q_full && !clearing;

  // out of range writes and queries with no actions are dropped here
  assign q_push = in_valid && in_ready && (in_kind ? (na != 5'd0) : (b_ok && a_ok));

endmodule

FILE: rtl/core/rms_queue.sv
// two entry request queue between front end and back end
// depends on rms_pkg
module rms_queue import rms_pkg::*; (
  input  logic     clk,
  input  logic     rst_n,
  input  logic     push,
  input  rms_cmd_t push_cmd,
  output logic     full,
  input  logic     pop,
  output logic     not_empty,
  output rms_cmd_t head
);

  rms_cmd_t   ent_r [2];
  logic       wp_r, rp_r;
  logic [1:0] cnt_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wp_r  <= 1'b0;
      rp_r  <= 1'b0;
      cnt_r <= 2'd0;
    end else begin
      if (push) wp_r <= !wp_r;
      if (pop) rp_r <= !rp_r;
      cnt_r <= cnt_r + 2'(push) - 2'(pop);
    end
  end

  always_ff @(posedge clk) begin
    if (push) ent_r[wp_r] <= push_cmd;
  end

  assign full      = cnt_r == 2'd2;
  assign not_empty = cnt_r != 2'd0;
  assign head      = ent_r[rp_r];

endmodule

FILE: rtl/core/rms_back.sv
// back end: regret store with clearing pass, bucket sum, serial divider, output register
// depends on rms_pkg
module rms_back import rms_pkg::*; (
  input  logic               clk,
  input  logic               rst_n,
  input  logic               cmd_valid,
  input  rms_cmd_t           cmd,
  output logic               cmd_pop,
  output logic               clearing,
  output logic               out_valid,
  input  logic               out_ready,
  output logic [3:0]         out_action_index,
  output logic [PROB_W-1:0]  out_probability,
  output logic               out_last
);

  localparam logic [2:0] S_CLEAR = 3'd0;
  localparam logic [2:0] S_IDLE  = 3'd1;
  localparam logic [2:0] S_READ  = 3'd2;
  localparam logic [2:0] S_LOAD  = 3'd3;
  localparam logic [2:0] S_DIV   = 3'd4;
  localparam logic [2:0] S_EMIT  = 3'd5;

  logic [31:0]       mem [STORE_DEPTH];
  logic [31:0]       rd_data_r;
  logic [POS_W-1:0]  pos_r [MAX_ACTIONS];

  logic [2:0]        state_r, state_nxt;
  logic [ADDR_W-1:0] addr_r, addr_nxt;
  logic [8:0]        stride_r, stride_nxt;
  logic [4:0]        na_r, na_nxt;
  logic [4:0]        rd_cnt_r, rd_cnt_nxt;
  logic [4:0]        rx_cnt_r, rx_cnt_nxt;
  logic              rd_vld_r, rd_vld_nxt;
  logic [SUM_W-1:0]  sum_r, sum_nxt;
  logic              uniform_r, uniform_nxt;
  logic [4:0]        act_r, act_nxt;
  logic [4:0]        step_r, step_nxt;
  logic [SUM_W-1:0]  rem_r, rem_nxt;
  logic [PROB_W-1:0] quo_r, quo_nxt;
  logic              ov_r, ov_nxt;
  logic [3:0]        oact_r, oact_nxt;
  logic [PROB_W-1:0] oprob_r, oprob_nxt;
  logic              olast_r, olast_nxt;

  logic              mem_we;
  logic [ADDR_W-1:0] mem_wa;
  logic [31:0]       mem_wd;
  logic              rd_issue;
  logic [POS_W-1:0]  rd_pos;
  logic [POS_W-1:0]  cur_pos;
  logic [SUM_W:0]    shifted;
  logic              slot_free;

  assign rd_pos  = rd_data_r[31] ? '0 : rd_data_r[POS_W-1:0];
  assign cur_pos = pos_r[act_r[3:0]];
  // the numerator is pos * 65536; its high part pos >> 1 is already below the sum
  assign shifted = {rem_r, (step_r == 5'd0) ? cur_pos[0] : 1'b0};
  assign slot_free = !ov_r || out_ready;

  always_comb begin
    state_nxt   = state_r;
    addr_nxt    = addr_r;
    stride_nxt  = stride_r;
    na_nxt      = na_r;
    rd_cnt_nxt  = rd_cnt_r;
    rx_cnt_nxt  = rx_cnt_r;
    rd_vld_nxt  = 1'b0;
    sum_nxt     = sum_r;
    uniform_nxt = uniform_r;
    act_nxt     = act_r;
    step_nxt    = step_r;
    rem_nxt     = rem_r;
    quo_nxt     = quo_r;
    ov_nxt      = ov_r && !out_ready;
    oact_nxt    = oact_r;
    oprob_nxt   = oprob_r;
    olast_nxt   = olast_r;
    mem_we      = 1'b0;
    mem_wa      = cmd.addr;
    mem_wd      = cmd.data;
    rd_issue    = 1'b0;
    cmd_pop     = 1'b0;

    unique case (state_r)
      S_CLEAR: begin
        mem_we   = 1'b1;
        mem_wa   = addr_r;
        mem_wd   = '0;
        addr_nxt = addr_r + 1'b1;
        if (addr_r == ADDR_W'(STORE_DEPTH - 1)) state_nxt = S_IDLE;
      end
      S_IDLE: begin
        if (cmd_valid) begin
          cmd_pop = 1'b1;
          if (!cmd.is_query) begin
            mem_we = 1'b1;
          end else begin
            addr_nxt    = cmd.addr;
            stride_nxt  = cmd.stride;
            na_nxt      = cmd.na;
            uniform_nxt = cmd.uniform;
            act_nxt     = '0;
            rd_cnt_nxt  = '0;
            rx_cnt_nxt  = '0;
            sum_nxt     = '0;
            state_nxt   = cmd.uniform ? S_EMIT : S_READ;
          end
        end
      end
      S_READ: begin
        if (rd_cnt_r != na_r) begin
          rd_issue   = 1'b1;
          rd_vld_nxt = 1'b1;
          addr_nxt   = addr_r + ADDR_W'(stride_r);
          rd_cnt_nxt = rd_cnt_r + 1'b1;
        end
        if (rd_vld_r) begin
          sum_nxt    = sum_r + SUM_W'(rd_pos);
          rx_cnt_nxt = rx_cnt_r + 1'b1;
        end
        if (rx_cnt_r == na_r) begin
          uniform_nxt = sum_r == '0;
          state_nxt   = (sum_r == '0) ? S_EMIT : S_LOAD;
        end
      end
      S_LOAD: begin
        rem_nxt   = SUM_W'(cur_pos[POS_W-1:1]);
        quo_nxt   = '0;
        step_nxt  = '0;
        state_nxt = S_DIV;
      end
      S_DIV: begin
        if (shifted >= {1'b0, sum_r}) begin
          rem_nxt = SUM_W'(shifted - {1'b0, sum_r});
          quo_nxt = {quo_r[PROB_W-2:0], 1'b1};
        end else begin
          rem_nxt = shifted[SUM_W-1:0];
          quo_nxt = {quo_r[PROB_W-2:0], 1'b0};
        end
        step_nxt = step_r + 1'b1;
        if (step_r == 5'(QSTEPS - 1)) state_nxt = S_EMIT;
      end
      S_EMIT: begin
        if (slot_free) begin
          ov_nxt    = 1'b1;
          oact_nxt  = act_r[3:0];
          oprob_nxt = uniform_r ? uniform_prob(na_r) : quo_r;
          olast_nxt = (act_r + 1'b1) == na_r;
          act_nxt   = act_r + 1'b1;
          if ((act_r + 1'b1) == na_r) state_nxt = S_IDLE;
          else if (!uniform_r) state_nxt = S_LOAD;
        end
      end
      default: state_nxt = S_IDLE;
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r  <= S_CLEAR;
      addr_r   <= '0;
      rd_vld_r <= 1'b0;
      ov_r     <= 1'b0;
    end else begin
      state_r  <= state_nxt;
      addr_r   <= addr_nxt;
      rd_vld_r <= rd_vld_nxt;
      ov_r     <= ov_nxt;
    end
  end

  always_ff @(posedge clk) begin
    stride_r  <= stride_nxt;
    na_r      <= na_nxt;
    rd_cnt_r  <= rd_cnt_nxt;
    rx_cnt_r  <= rx_cnt_nxt;
    sum_r     <= sum_nxt;
    uniform_r <= uniform_nxt;
    act_r     <= act_nxt;
    step_r    <= step_nxt;
    rem_r     <= rem_nxt;
    quo_r     <= quo_nxt;
    oact_r    <= oact_nxt;
    oprob_r   <= oprob_nxt;
    olast_r   <= olast_nxt;
    if (state_r == S_READ && rd_vld_r) pos_r[rx_cnt_r[3:0]] <= rd_pos;
  end

  always_ff @(posedge clk) begin
    if (mem_we) mem[mem_wa] <= mem_wd;
    if (rd_issue) rd_data_r <= mem[addr_r];
  end

  assign clearing         = state_r == S_CLEAR;
  assign out_valid        = ov_r;
  assign out_action_index = oact_r;
  assign out_probability  = oprob_r;
  assign out_last         = olast_r;

endmodule

FILE: rtl/core/regret_matching_strategy_top.sv
// top level of the regret matching strategy block
// depends on rms_pkg, rms_front, rms_queue, rms_back
//
// After reset the block sweeps the 4096-entry regret store to zero, one entry
// a cycle, and takes no request during the sweep; configuration writes
// are taken at any time. A write request is stored as it leaves the queue. A
// query leaves the queue, then reads and sums the bucket through the single
// store read port, then for each action loads the operand and runs the
// bit-serial divider (one quotient bit a cycle) before its result is
// registered. A bucket out of range gives the uniform value without reading
// the store; a bucket whose regrets sum to zero gives it after the sum. A
// stalled receiver holds up each result. A two-entry queue lets requests
// arrive while a query is in progress.
module regret_matching_strategy_top import rms_pkg::*; (
  input  logic               clk,
  input  logic               rst_n,
  input  logic               cfg_we,
  input  logic [1:0]         cfg_index,
  input  logic [8:0]         cfg_wdata,
  input  logic               in_valid,
  output logic               in_ready,
  input  logic               in_kind,
  input  logic [7:0]         in_bucket,
  input  logic [3:0]         in_action,
  input  logic signed [31:0] in_regret_value,
  output logic               out_valid,
  input  logic               out_ready,
  output logic [3:0]         out_action_index,
  output logic [PROB_W-1:0]  out_probability,
  output logic               out_last
);

  rms_cmd_t q_cmd, q_head;
  logic     q_push, q_full, q_pop, q_not_empty, clearing;

  rms_front u_front (
    .clk, .rst_n, .cfg_we, .cfg_index, .cfg_wdata,
    .in_valid, .in_ready, .in_kind, .in_bucket, .in_action,
    .in_regret_value(in_regret_value),
    .clearing, .q_full, .q_push, .q_cmd
  );

  rms_queue u_queue (
    .clk, .rst_n, .push(q_push), .push_cmd(q_cmd), .full(q_full),
    .pop(q_pop), .not_empty(q_not_empty), .head(q_head)
  );

  rms_back u_back (
    .clk, .rst_n, .cmd_valid(q_not_empty), .cmd(q_head), .cmd_pop(q_pop),
    .clearing, .out_valid, .out_ready, .out_action_index,
    .out_probability, .out_last
  );

  a_no_request_while_clearing: assert property (@(posedge clk) disable iff (!rst_n)
    clearing |-> !in_ready) else $error("request accepted during clearing pass");

  a_prob_in_range: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid |-> out_probability <= ONE_Q16) else $error("probability above one");

  a_no_queue_overflow: assert property (@(posedge clk) disable iff (!rst_n)
    q_push |-> !q_full) else $error("request queue overflow");

  a_clear_after_reset: assert property (@(posedge clk)
    $rose(rst_n) |-> clearing) else $error("clearing pass missing after reset");

endmodule
